@@ design/line_stipple_distance_coords_unit_defines.svh @@
// Assertion macros shared by the line stipple distance RTL.
`ifndef LINE_STIPPLE_DISTANCE_COORDS_UNIT_DEFINES_SVH
`define LINE_STIPPLE_DISTANCE_COORDS_UNIT_DEFINES_SVH
`ifndef SYNTHESIS
`define LSDC_ASSERT(lbl, prop, msg) \
   lbl: assert property (@(posedge clock) disable iff (reset) prop) else $error(msg);
`define LSDC_ASSERT_RST(lbl, prop, msg) \
   lbl: assert property (@(posedge clock) prop) else $error(msg);
`else
`define LSDC_ASSERT(lbl, prop, msg)
`define LSDC_ASSERT_RST(lbl, prop, msg)
`endif
`endif

@@ design/lsdc_pkg.sv @@
// Shared types and constants for the line stipple distance unit.
`default_nettype none
package lsdc_pkg;
   localparam int LSDC_FRAC_BITS   = 16;
   localparam int LSDC_VP_W        = 15;
   localparam int LSDC_FACTOR_W    = 9;
   localparam int LSDC_CSR_IDX_W   = 2;
   localparam int LSDC_CSR_DATA_W  = 32;
   localparam int LSDC_QUEUE_DEPTH = 2;

   localparam logic [LSDC_CSR_IDX_W-1:0] CSR_VP_WIDTH  = 2'd0;
   localparam logic [LSDC_CSR_IDX_W-1:0] CSR_VP_HEIGHT = 2'd1;
   localparam logic [LSDC_CSR_IDX_W-1:0] CSR_FACTOR    = 2'd2;

   localparam logic [LSDC_VP_W-1:0]     VP_WIDTH_RST  = 15'd640;
   localparam logic [LSDC_VP_W-1:0]     VP_HEIGHT_RST = 15'd480;
   localparam logic [LSDC_FACTOR_W-1:0] FACTOR_RST    = 9'd1;

   typedef struct packed {
      logic [31:0] clip_x;
      logic [31:0] clip_y;
      logic [31:0] clip_w;
      logic [15:0] vertex_index;
      logic        clear_len;
      logic        add_dist;
   } lsdc_entry_type;

   typedef enum logic [3:0] {
      BK_IDLE, BK_MUL, BK_PREP, BK_DIV, BK_SCREEN, BK_DIFF, BK_SQX, BK_SQY,
      BK_SUM, BK_SQRT, BK_FPREP, BK_FDIV, BK_ACC
   } back_state_type;

   typedef struct packed {
      logic pop;
      logic out_free;
      logic done;
   } back_ctl_type;
endpackage
`default_nettype wire

@@ design/line_stipple_distance_coords_unit.sv @@
// Line stipple distance unit: top level with configuration registers.
// Each request is one clip-space vertex. It is divided by w, scaled to screen
// space, and the screen distance to the previous point, divided by factor*16,
// is added to a saturating run length returned as stipple coordinate s.
// When a distance is added, a vertex passes through two 31-step perspective
// dividers in parallel, a 32-step square root and a 28-step factor divider,
// all sequenced by the back end; otherwise it skips the distance steps. A
// two-entry queue lets the next request be accepted while one is at work.
`default_nettype none
module line_stipple_distance_coords_unit import lsdc_pkg::*; #(
   parameter int FRAC_BITS = LSDC_FRAC_BITS
) (
   input  wire logic                       clock,
   input  wire logic                       reset,
   input  wire logic                       req_valid,
   output      logic                       req_ready,
   input  wire logic [31:0]                req_clip_x,
   input  wire logic [31:0]                req_clip_y,
   input  wire logic [31:0]                req_clip_w,
   input  wire logic [15:0]                req_vertex_index,
   input  wire logic                       req_primitive_start,
   input  wire logic                       req_line_kind,
   output      logic                       rsp_valid,
   input  wire logic                       rsp_ready,
   output      logic [31:0]                rsp_stipple_coord,
   output      logic [15:0]                rsp_coord_index,
   input  wire logic                       csr_valid,
   output      logic                       csr_ready,
   input  wire logic [LSDC_CSR_IDX_W-1:0]  csr_index,
   input  wire logic [LSDC_CSR_DATA_W-1:0] csr_wdata
);
   logic [LSDC_VP_W-1:0]     vp_width_ff, vp_height_ff;
   logic [LSDC_FACTOR_W-1:0] factor_ff;
   logic                     q_full, q_push, q_pop, q_valid;
   lsdc_entry_type           q_in, q_out;

   assign csr_ready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         vp_width_ff  <= VP_WIDTH_RST;
         vp_height_ff <= VP_HEIGHT_RST;
         factor_ff    <= FACTOR_RST;
      end else if (csr_valid && csr_ready) begin
         case (csr_index)
            CSR_VP_WIDTH:  vp_width_ff  <= csr_wdata[LSDC_VP_W-1:0];
            CSR_VP_HEIGHT: vp_height_ff <= csr_wdata[LSDC_VP_W-1:0];
            CSR_FACTOR:    factor_ff    <= csr_wdata[LSDC_FACTOR_W-1:0];
            default: begin
            end
         endcase
      end
   end

   lsdc_front u_front (
      .clock               (clock),
      .reset               (reset),
      .req_valid           (req_valid),
      .req_ready           (req_ready),
      .req_clip_x          (req_clip_x),
      .req_clip_y          (req_clip_y),
      .req_clip_w          (req_clip_w),
      .req_vertex_index    (req_vertex_index),
      .req_primitive_start (req_primitive_start),
      .req_line_kind       (req_line_kind),
      .q_full              (q_full),
      .q_push              (q_push),
      .q_data              (q_in)
   );

   lsdc_queue u_queue (
      .clock     (clock),
      .reset     (reset),
      .push      (q_push),
      .push_data (q_in),
      .full      (q_full),
      .pop       (q_pop),
      .valid     (q_valid),
      .pop_data  (q_out)
   );

   lsdc_back #(.FRAC_BITS(FRAC_BITS)) u_back (
      .clock             (clock),
      .reset             (reset),
      .q_valid           (q_valid),
      .q_data            (q_out),
      .q_pop             (q_pop),
      .vp_width          (vp_width_ff),
      .vp_height         (vp_height_ff),
      .factor            (factor_ff),
      .rsp_valid         (rsp_valid),
      .rsp_ready         (rsp_ready),
      .rsp_stipple_coord (rsp_stipple_coord),
      .rsp_coord_index   (rsp_coord_index)
   );
endmodule
`default_nettype wire

@@ design/lsdc_front.sv @@
// Front end: accepts requests and classifies each vertex for the back end.
`default_nettype none
module lsdc_front import lsdc_pkg::*; (
   input  wire logic           clock,
   input  wire logic           reset,
   input  wire logic           req_valid,
   output      logic           req_ready,
   input  wire logic [31:0]    req_clip_x,
   input  wire logic [31:0]    req_clip_y,
   input  wire logic [31:0]    req_clip_w,
   input  wire logic [15:0]    req_vertex_index,
   input  wire logic           req_primitive_start,
   input  wire logic           req_line_kind,
   input  wire logic           q_full,
   output      logic           q_push,
   output      lsdc_entry_type q_data
);
   logic pair_second_ff, pair_second_in, pair_eff;

   assign req_ready = !q_full;
   assign q_push    = req_valid && req_ready;
   assign pair_eff  = req_primitive_start ? 1'b0 : pair_second_ff;

   always_comb begin
      q_data.clip_x       = req_clip_x;
      q_data.clip_y       = req_clip_y;
      q_data.clip_w       = req_clip_w;
      q_data.vertex_index = req_vertex_index;
      q_data.clear_len    = req_primitive_start;
      q_data.add_dist     = req_line_kind ? pair_eff : !req_primitive_start;
      pair_second_in      = req_line_kind ? !pair_eff : 1'b0;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         pair_second_ff <= 1'b0;
      end else if (q_push) begin
         pair_second_ff <= pair_second_in;
      end
   end
endmodule
`default_nettype wire

@@ design/lsdc_queue.sv @@
// Short request queue between front and back end.
`default_nettype none
`include "line_stipple_distance_coords_unit_defines.svh"
module lsdc_queue import lsdc_pkg::*; (
   input  wire logic           clock,
   input  wire logic           reset,
   input  wire logic           push,
   input  wire lsdc_entry_type push_data,
   output      logic           full,
   input  wire logic           pop,
   output      logic           valid,
   output      lsdc_entry_type pop_data
);
   localparam int DEPTH = LSDC_QUEUE_DEPTH;
   localparam int PW    = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int CW    = $clog2(DEPTH + 1);

   lsdc_entry_type       mem_ff [DEPTH];
   logic [PW-1:0]        wr_ptr_ff, rd_ptr_ff;
   logic [CW-1:0]        count_ff;

   assign full     = (count_ff == CW'(DEPTH));
   assign valid    = (count_ff != '0);
   assign pop_data = mem_ff[rd_ptr_ff];

   always_ff @(posedge clock) begin
      if (push) begin
         mem_ff[wr_ptr_ff] <= push_data;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         if (push) begin
            wr_ptr_ff <= (wr_ptr_ff == PW'(DEPTH - 1)) ? '0 : wr_ptr_ff + 1'b1;
         end
         if (pop) begin
            rd_ptr_ff <= (rd_ptr_ff == PW'(DEPTH - 1)) ? '0 : rd_ptr_ff + 1'b1;
         end
         if (push && !pop) begin
            count_ff <= count_ff + 1'b1;
         end else if (pop && !push) begin
            count_ff <= count_ff - 1'b1;
         end
      end
   end

   `LSDC_ASSERT(a_q_count, count_ff <= CW'(DEPTH), "queue count out of range")
   `LSDC_ASSERT(a_q_pop, pop |-> valid, "pop from empty queue")
endmodule
`default_nettype wire

@@ design/lsdc_back.sv @@
// Back end: screen transform, distance, square root and stipple length accumulate.
`default_nettype none
`include "line_stipple_distance_coords_unit_defines.svh"
module lsdc_back import lsdc_pkg::*; #(
   parameter int FRAC_BITS = LSDC_FRAC_BITS
) (
   input  wire logic                     clock,
   input  wire logic                     reset,
   input  wire logic                     q_valid,
   input  wire lsdc_entry_type           q_data,
   output      logic                     q_pop,
   input  wire logic [LSDC_VP_W-1:0]     vp_width,
   input  wire logic [LSDC_VP_W-1:0]     vp_height,
   input  wire logic [LSDC_FACTOR_W-1:0] factor,
   output      logic                     rsp_valid,
   input  wire logic                     rsp_ready,
   output      logic [31:0]              rsp_stipple_coord,
   output      logic [15:0]              rsp_coord_index
);
   localparam int NUM_W = 32 + LSDC_VP_W;
   localparam int N_W   = NUM_W + FRAC_BITS;
   localparam int HI_W  = N_W - 31;
   localparam int FD_W  = 28;
   localparam logic [31:0] W_ONE   = 32'(1) << FRAC_BITS;
   localparam logic [31:0] MAG_MAX = 32'h7FFF_FFFF;

   back_state_type state_ff, state_in;
   back_ctl_type   ctl;

   lsdc_entry_type cur_ff;
   logic [NUM_W-1:0] num_x_ff, num_y_ff;
   logic [32:0]      den_ff;
   logic             neg_x_ff, neg_y_ff, sat_x_ff, sat_y_ff;
   logic [33:0]      rem_x_ff, rem_y_ff;
   logic [30:0]      low_x_ff, low_y_ff, quo_x_ff, quo_y_ff;
   logic [5:0]       cnt_ff;
   logic [31:0]      sx_ff, sy_ff, prev_x_ff, prev_y_ff;
   logic [30:0]      dx_ff, dy_ff;
   logic [61:0]      p_ff, acc_ff;
   logic [63:0]      sqv_ff, sqr_ff, sqb_ff;
   logic [9:0]       fd_rem_ff;
   logic [FD_W-1:0]  fd_num_ff, fd_q_ff;
   logic [31:0]      run_ff, coord_ff;
   logic [15:0]      idx_ff;
   logic             rsp_valid_ff;

   // operand conditioning
   logic [31:0]      mag_cx, mag_cy, mag_w;
   logic             neg_w;
   logic [N_W-1:0]   n_x, n_y;
   logic [HI_W-1:0]  hi_x, hi_y;
   logic [33:0]      t_x, t_y;
   logic [31:0]      mag_sx, mag_sy;
   logic [32:0]      d_x, d_y, a_x, a_y;
   logic [63:0]      sq_try;
   logic [9:0]       fd_t;
   logic [8:0]       f_eff;
   logic [31:0]      base;
   logic [32:0]      len_sum;
   logic [31:0]      len_new;

   always_comb begin
      mag_cx = cur_ff.clip_x[31] ? (~cur_ff.clip_x + 32'd1) : cur_ff.clip_x;
      mag_cy = cur_ff.clip_y[31] ? (~cur_ff.clip_y + 32'd1) : cur_ff.clip_y;
      if (cur_ff.clip_w == '0) begin
         mag_w = W_ONE;
         neg_w = 1'b0;
      end else begin
         mag_w = cur_ff.clip_w[31] ? (~cur_ff.clip_w + 32'd1) : cur_ff.clip_w;
         neg_w = cur_ff.clip_w[31];
      end
      n_x    = {num_x_ff, FRAC_BITS'(0)};
      n_y    = {num_y_ff, FRAC_BITS'(0)};
      hi_x   = n_x[N_W-1:31];
      hi_y   = n_y[N_W-1:31];
      t_x    = {rem_x_ff[32:0], low_x_ff[30]};
      t_y    = {rem_y_ff[32:0], low_y_ff[30]};
      mag_sx = sat_x_ff ? MAG_MAX : {1'b0, quo_x_ff};
      mag_sy = sat_y_ff ? MAG_MAX : {1'b0, quo_y_ff};
      d_x    = {sx_ff[31], sx_ff} - {prev_x_ff[31], prev_x_ff};
      d_y    = {sy_ff[31], sy_ff} - {prev_y_ff[31], prev_y_ff};
      a_x    = d_x[32] ? (~d_x + 33'd1) : d_x;
      a_y    = d_y[32] ? (~d_y + 33'd1) : d_y;
      sq_try = sqr_ff + sqb_ff;
      fd_t   = {fd_rem_ff[8:0], fd_num_ff[FD_W-1]};
      if (factor == '0) begin
         f_eff = 9'd1;
      end else if (factor > 9'd256) begin
         f_eff = 9'd256;
      end else begin
         f_eff = factor;
      end
      base    = cur_ff.clear_len ? 32'd0 : run_ff;
      len_sum = {1'b0, base} + 33'({fd_q_ff});
      if (!cur_ff.add_dist) begin
         len_new = base;
      end else if (len_sum[32]) begin
         len_new = 32'hFFFF_FFFF;
      end else begin
         len_new = len_sum[31:0];
      end
   end

   // control outputs
   always_comb begin
      ctl.pop      = (state_ff == BK_IDLE) && q_valid;
      ctl.out_free = !rsp_valid_ff || rsp_ready;
      ctl.done     = (state_ff == BK_ACC) && ctl.out_free;
   end

   // next state
   always_comb begin
      state_in = state_ff;
      case (state_ff)
         BK_IDLE:   if (ctl.pop) state_in = BK_MUL;
         BK_MUL:    state_in = BK_PREP;
         BK_PREP:   state_in = BK_DIV;
         BK_DIV:    if (cnt_ff == 6'd30) state_in = BK_SCREEN;
         BK_SCREEN: state_in = cur_ff.add_dist ? BK_DIFF : BK_ACC;
         BK_DIFF:   state_in = BK_SQX;
         BK_SQX:    state_in = BK_SQY;
         BK_SQY:    state_in = BK_SUM;
         BK_SUM:    state_in = BK_SQRT;
         BK_SQRT:   if (cnt_ff == 6'd31) state_in = BK_FPREP;
         BK_FPREP:  state_in = BK_FDIV;
         BK_FDIV:   if (cnt_ff == 6'(FD_W - 1)) state_in = BK_ACC;
         BK_ACC:    if (ctl.done) state_in = BK_IDLE;
         default:   state_in = BK_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= BK_IDLE;
         run_ff       <= '0;
         prev_x_ff    <= '0;
         prev_y_ff    <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff <= state_in;
         if (ctl.done) begin
            run_ff       <= len_new;
            prev_x_ff    <= sx_ff;
            prev_y_ff    <= sy_ff;
            rsp_valid_ff <= 1'b1;
         end else if (rsp_ready) begin
            rsp_valid_ff <= 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      case (state_ff)
         BK_IDLE: begin
            if (ctl.pop) cur_ff <= q_data;
         end
         BK_MUL: begin
            num_x_ff <= NUM_W'(mag_cx) * NUM_W'(vp_width);
            num_y_ff <= NUM_W'(mag_cy) * NUM_W'(vp_height);
            den_ff   <= {mag_w, 1'b0};
            neg_x_ff <= cur_ff.clip_x[31] ^ neg_w;
            neg_y_ff <= cur_ff.clip_y[31] ^ neg_w;
         end
         BK_PREP: begin
            sat_x_ff <= 64'(hi_x) >= 64'(den_ff);
            sat_y_ff <= 64'(hi_y) >= 64'(den_ff);
            rem_x_ff <= (64'(hi_x) >= 64'(den_ff)) ? '0 : 34'(hi_x);
            rem_y_ff <= (64'(hi_y) >= 64'(den_ff)) ? '0 : 34'(hi_y);
            low_x_ff <= n_x[30:0];
            low_y_ff <= n_y[30:0];
            cnt_ff   <= '0;
         end
         BK_DIV: begin
            if (t_x >= {1'b0, den_ff}) begin
               rem_x_ff <= t_x - {1'b0, den_ff};
               quo_x_ff <= {quo_x_ff[29:0], 1'b1};
            end else begin
               rem_x_ff <= t_x;
               quo_x_ff <= {quo_x_ff[29:0], 1'b0};
            end
            if (t_y >= {1'b0, den_ff}) begin
               rem_y_ff <= t_y - {1'b0, den_ff};
               quo_y_ff <= {quo_y_ff[29:0], 1'b1};
            end else begin
               rem_y_ff <= t_y;
               quo_y_ff <= {quo_y_ff[29:0], 1'b0};
            end
            low_x_ff <= {low_x_ff[29:0], 1'b0};
            low_y_ff <= {low_y_ff[29:0], 1'b0};
            cnt_ff   <= cnt_ff + 6'd1;
         end
         BK_SCREEN: begin
            sx_ff <= neg_x_ff ? (~mag_sx + 32'd1) : mag_sx;
            sy_ff <= neg_y_ff ? (~mag_sy + 32'd1) : mag_sy;
         end
         BK_DIFF: begin
            dx_ff <= (a_x > 33'(MAG_MAX)) ? MAG_MAX[30:0] : a_x[30:0];
            dy_ff <= (a_y > 33'(MAG_MAX)) ? MAG_MAX[30:0] : a_y[30:0];
         end
         BK_SQX: begin
            p_ff <= 62'(dx_ff) * 62'(dx_ff);
         end
         BK_SQY: begin
            acc_ff <= p_ff;
            p_ff   <= 62'(dy_ff) * 62'(dy_ff);
         end
         BK_SUM: begin
            sqv_ff <= 64'(acc_ff) + 64'(p_ff);
            sqr_ff <= '0;
            sqb_ff <= 64'(1) << 62;
            cnt_ff <= '0;
         end
         BK_SQRT: begin
            if (sqv_ff >= sq_try) begin
               sqv_ff <= sqv_ff - sq_try;
               sqr_ff <= (sqr_ff >> 1) + sqb_ff;
            end else begin
               sqr_ff <= sqr_ff >> 1;
            end
            sqb_ff <= sqb_ff >> 2;
            cnt_ff <= cnt_ff + 6'd1;
         end
         BK_FPREP: begin
            fd_num_ff <= sqr_ff[31:4];
            fd_rem_ff <= '0;
            cnt_ff    <= '0;
         end
         BK_FDIV: begin
            if (fd_t >= {1'b0, f_eff}) begin
               fd_rem_ff <= fd_t - {1'b0, f_eff};
               fd_q_ff   <= {fd_q_ff[FD_W-2:0], 1'b1};
            end else begin
               fd_rem_ff <= fd_t;
               fd_q_ff   <= {fd_q_ff[FD_W-2:0], 1'b0};
            end
            fd_num_ff <= {fd_num_ff[FD_W-2:0], 1'b0};
            cnt_ff    <= cnt_ff + 6'd1;
         end
         BK_ACC: begin
            if (ctl.done) begin
               coord_ff <= len_new;
               idx_ff   <= cur_ff.vertex_index;
            end
         end
         default: begin
         end
      endcase
   end

   assign q_pop             = ctl.pop;
   assign rsp_valid         = rsp_valid_ff;
   assign rsp_stipple_coord = coord_ff;
   assign rsp_coord_index   = idx_ff;

   `LSDC_ASSERT(a_pop_starts, ctl.pop |=> (state_ff == BK_MUL), "popped request not started")
   `LSDC_ASSERT(a_div_cnt, (state_ff == BK_DIV) |-> (cnt_ff < 6'd31), "divide count overrun")
   `LSDC_ASSERT(a_done_out, ctl.done |=> rsp_valid_ff, "finished request not presented")
   `LSDC_ASSERT_RST(a_reset, reset |=> (state_ff == BK_IDLE && !rsp_valid_ff), "reset not idle")
endmodule
`default_nettype wire

@@ tb/testbench.sv @@
// Self-checking testbench for the line stipple distance coordinate unit.
`timescale 1ns / 1ps
module testbench;
   import lsdc_pkg::*;

   localparam logic LINE_STRIP = 1'b0;
   localparam logic LINE_PAIRS = 1'b1;
   localparam int   CYCLE_LIMIT = 3000000;
   localparam int   DRAIN_CYCLES = 300;
   localparam int   RANDOM_ITEMS = 1100;
   localparam int   NUM_PHASES = 6;
   localparam logic [63:0] MAG_MAX = 64'h7FFF_FFFF;

   typedef struct {
      logic [31:0] coord;
      logic [15:0] index;
   } coord_result_type;

   typedef struct {
      logic [31:0] x;
      logic [31:0] y;
      logic [31:0] w;
      logic [15:0] index;
      logic        start;
      logic        kind;
      bit          typed;
      logic [31:0] coord;
   } vertex_row_type;

   logic        clock = 1'b0;
   logic        reset = 1'b1;
   logic        req_valid = 1'b0;
   logic        req_ready;
   logic [31:0] req_clip_x = '0;
   logic [31:0] req_clip_y = '0;
   logic [31:0] req_clip_w = '0;
   logic [15:0] req_vertex_index = '0;
   logic        req_primitive_start = 1'b0;
   logic        req_line_kind = 1'b0;
   logic        rsp_valid;
   logic        rsp_ready = 1'b0;
   logic [31:0] rsp_stipple_coord;
   logic [15:0] rsp_coord_index;
   logic        csr_valid = 1'b0;
   logic        csr_ready;
   logic [LSDC_CSR_IDX_W-1:0]  csr_index = '0;
   logic [LSDC_CSR_DATA_W-1:0] csr_wdata = '0;

   coord_result_type pending_coords[$];
   vertex_row_type   directed_rows[$];
   int unsigned   error_count = 0;
   int unsigned   cycle_count = 0;
   int unsigned   send_idle_pct = 0;
   int unsigned   recv_idle_pct = 0;
   int unsigned   hold_cycles = 0;

   // predictor state and registers
   logic [14:0] vp_width;
   logic [14:0] vp_height;
   logic [8:0]  factor_reg;
   logic [31:0] run_len;
   logic [31:0] last_sx;
   logic [31:0] last_sy;
   logic        second_of_pair;

   line_stipple_distance_coords_unit u_top (.*);

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count > CYCLE_LIMIT) begin
         $display("line_stipple_distance_coords_unit test failed");
         $finish;
      end
   end

   function automatic logic [31:0] screen_coord(logic [31:0] c, logic [31:0] w,
                                                logic [14:0] vp);
      logic [63:0] mag_c, mag_w, num, den, q, r, mag;
      logic        neg;
      mag_c = c[31] ? ((64'h1_0000_0000 - {32'd0, c}) & 64'h1_FFFF_FFFF) : {32'd0, c};
      mag_w = w[31] ? ((64'h1_0000_0000 - {32'd0, w}) & 64'h1_FFFF_FFFF) : {32'd0, w};
      neg = c[31] ^ w[31];
      if (w == 32'd0) begin
         mag_w = 64'd1 << LSDC_FRAC_BITS;
         neg = c[31];
      end
      num = mag_c * {49'd0, vp};
      den = 2 * mag_w;
      q = num / den;
      r = num % den;
      if (q > (MAG_MAX >> LSDC_FRAC_BITS)) mag = MAG_MAX;
      else mag = (q << LSDC_FRAC_BITS) + ((r << LSDC_FRAC_BITS) / den);
      if (mag > MAG_MAX) mag = MAG_MAX;
      return neg ? (32'd0 - mag[31:0]) : mag[31:0];
   endfunction

   function automatic logic [63:0] delta_mag(logic [31:0] a, logic [31:0] b);
      longint d;
      d = longint'(signed'(a)) - longint'(signed'(b));
      if (d < 0) d = -d;
      return (d > longint'(MAG_MAX)) ? MAG_MAX : 64'(d);
   endfunction

   function automatic logic [63:0] int_sqrt(logic [63:0] v);
      logic [63:0] res, b;
      res = 0;
      b = 64'd1 << 62;
      while (b > v) b = b >> 2;
      while (b != 0) begin
         if (v >= res + b) begin
            v = v - (res + b);
            res = (res >> 1) + b;
         end else begin
            res = res >> 1;
         end
         b = b >> 2;
      end
      return res;
   endfunction

   task automatic add_segment(logic [31:0] sx, logic [31:0] sy);
      logic [63:0] dx, dy, f, sum;
      dx = delta_mag(sx, last_sx);
      dy = delta_mag(sy, last_sy);
      f = factor_reg;
      if (f == 0) f = 1;
      if (f > 256) f = 256;
      sum = {32'd0, run_len} + int_sqrt(dx * dx + dy * dy) / (f * 16);
      run_len = (sum > 64'hFFFF_FFFF) ? 32'hFFFF_FFFF : sum[31:0];
   endtask

   task automatic advance_length(vertex_row_type v, output logic [31:0] coord);
      logic [31:0] sx, sy;
      sx = screen_coord(v.x, v.w, vp_width);
      sy = screen_coord(v.y, v.w, vp_height);
      if (v.start) begin
         run_len = 0;
         second_of_pair = 1'b0;
      end
      if (v.kind == LINE_STRIP) begin
         if (!v.start) add_segment(sx, sy);
         second_of_pair = 1'b0;
      end else if (second_of_pair) begin
         add_segment(sx, sy);
         second_of_pair = 1'b0;
      end else begin
         second_of_pair = 1'b1;
      end
      last_sx = sx;
      last_sy = sy;
      coord = run_len;
   endtask

   task automatic send_vertex(vertex_row_type v);
      logic [31:0]      coord;
      coord_result_type exp_res;
      while ($urandom_range(99) < send_idle_pct) begin
         req_valid <= 1'b0;
         @(posedge clock);
      end
      req_valid <= 1'b1;
      req_clip_x <= v.x;
      req_clip_y <= v.y;
      req_clip_w <= v.w;
      req_vertex_index <= v.index;
      req_primitive_start <= v.start;
      req_line_kind <= v.kind;
      @(posedge clock);
      while (!req_ready) @(posedge clock);
      advance_length(v, coord);
      exp_res.coord = v.typed ? v.coord : coord;
      exp_res.index = v.index;
      pending_coords.push_back(exp_res);
   endtask

   task automatic write_csr(logic [LSDC_CSR_IDX_W-1:0] idx, logic [31:0] data);
      csr_valid <= 1'b1;
      csr_index <= idx;
      csr_wdata <= data;
      @(posedge clock);
      while (!csr_ready) @(posedge clock);
      csr_valid <= 1'b0;
      case (idx)
         CSR_VP_WIDTH:  vp_width = data[14:0];
         CSR_VP_HEIGHT: vp_height = data[14:0];
         CSR_FACTOR:    factor_reg = data[8:0];
         default: ;
      endcase
   endtask

   task automatic add_row(logic [31:0] x, logic [31:0] y, logic [31:0] w, logic [15:0] idx,
                          logic st, logic kind, bit typed, logic [31:0] coord);
      vertex_row_type r;
      r.x = x; r.y = y; r.w = w; r.index = idx;
      r.start = st; r.kind = kind; r.typed = typed; r.coord = coord;
      directed_rows.push_back(r);
   endtask

   function automatic logic [31:0] rand_clip();
      int unsigned sel;
      sel = $urandom_range(99);
      if (sel < 50) return $urandom_range(32'h40000) - 32'h20000;
      if (sel < 80) return $urandom;
      case ($urandom_range(3))
         0: return 32'h8000_0000;
         1: return 32'h7FFF_FFFF;
         2: return 32'h0;
         default: return 32'hFFFF_FFFF;
      endcase
   endfunction

   function automatic logic [31:0] rand_w();
      int unsigned sel;
      sel = $urandom_range(99);
      if (sel < 40) return $urandom_range(32'h30000, 32'h8000);
      if (sel < 55) return 32'h0;
      if (sel < 75) return $urandom;
      if (sel < 90) return 32'd0 - $urandom_range(32'h30000, 32'h8000);
      return $urandom_range(32'hFF, 32'h1);
   endfunction

   task automatic wait_idle();
      while (pending_coords.size() != 0) @(posedge clock);
      repeat (4) @(posedge clock);
   endtask

   // response side: check, then choose ready for the next cycle
   always @(posedge clock) begin
      coord_result_type exp_res;
      if (!reset && rsp_valid && rsp_ready) begin
         if (pending_coords.size() == 0) begin
            $display("%0t: unexpected response coord=%h index=%h", $time,
                     rsp_stipple_coord, rsp_coord_index);
            error_count++;
         end else begin
            exp_res = pending_coords.pop_front();
            if (rsp_stipple_coord !== exp_res.coord) begin
               $display("%0t: stipple_coord expected %h actual %h", $time,
                        exp_res.coord, rsp_stipple_coord);
               error_count++;
            end
            if (rsp_coord_index !== exp_res.index) begin
               $display("%0t: coord_index expected %h actual %h", $time,
                        exp_res.index, rsp_coord_index);
               error_count++;
            end
         end
      end
      if (hold_cycles > 0) begin
         hold_cycles <= hold_cycles - 1;
         rsp_ready <= 1'b0;
      end else begin
         rsp_ready <= ($urandom_range(99) >= recv_idle_pct);
      end
   end

   initial begin
      vertex_row_type v;
      int unsigned left;
      int unsigned n;
      bit          pairs;
      vp_width = VP_WIDTH_RST;
      vp_height = VP_HEIGHT_RST;
      factor_reg = FACTOR_RST;
      run_len = 0;
      last_sx = 0;
      last_sy = 0;
      second_of_pair = 1'b0;

      repeat (4) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // chaining from the origin with no start, then plain strips and pairs
      add_row(32'h10000, 32'h0, 32'h10000, 16'h0000, 1'b0, LINE_STRIP, 1, 32'h140000);
      add_row(32'h0, 32'h0, 32'h10000, 16'h0001, 1'b1, LINE_STRIP, 1, 32'h0);
      add_row(32'h10000, 32'h0, 32'h10000, 16'h0002, 1'b0, LINE_STRIP, 1, 32'h140000);
      add_row(32'h10000, 32'h10000, 32'h0, 16'h0003, 1'b0, LINE_STRIP, 0, 0);
      add_row(32'h8000_0000, 32'h7FFF_FFFF, 32'h1, 16'hFFFF, 1'b0, LINE_STRIP, 0, 0);
      add_row(32'h7FFF_FFFF, 32'h8000_0000, 32'h1, 16'h8000, 1'b0, LINE_STRIP, 0, 0);
      add_row(32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h8000_0000, 16'h7FFF, 1'b0, LINE_STRIP, 0, 0);
      add_row(32'hFFFF_FFFF, 32'h8000_0000, 32'hFFFF_FFFF, 16'h1234, 1'b0, LINE_STRIP, 0, 0);
      add_row(32'h0, 32'h0, 32'h10000, 16'h0010, 1'b1, LINE_PAIRS, 1, 32'h0);
      add_row(32'h20000, 32'hFFFE_0000, 32'h10000, 16'h0011, 1'b0, LINE_PAIRS, 0, 0);
      add_row(32'h8000_0000, 32'h0, 32'h7FFF_FFFF, 16'h0012, 1'b0, LINE_PAIRS, 0, 0);
      add_row(32'h7FFF_FFFF, 32'h1, 32'h0, 16'h0013, 1'b0, LINE_PAIRS, 0, 0);
      add_row(32'h5555_5555, 32'hAAAA_AAAA, 32'h0, 16'h0014, 1'b0, LINE_STRIP, 0, 0);
      add_row(32'hAAAA_AAAA, 32'h5555_5555, 32'h1, 16'h0015, 1'b0, LINE_PAIRS, 0, 0);
      add_row(32'h8000_0000, 32'h8000_0000, 32'h1, 16'h0016, 1'b0, LINE_PAIRS, 0, 0);
      add_row(32'h10000, 32'h10000, 32'h10000, 16'h0017, 1'b1, LINE_PAIRS, 1, 32'h0);
      add_row(32'h0, 32'h0, 32'hFFFF_0000, 16'h0018, 1'b0, LINE_STRIP, 0, 0);
      add_row(32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h1, 16'h0019, 1'b0, LINE_STRIP, 0, 0);
      add_row(32'h8000_0000, 32'h8000_0000, 32'h1, 16'h001A, 1'b0, LINE_STRIP, 0, 0);
      foreach (directed_rows[i]) send_vertex(directed_rows[i]);

      for (int phase = 0; phase < NUM_PHASES; phase++) begin
         req_valid <= 1'b0;
         wait_idle();
         case (phase)
            0: begin write_csr(CSR_VP_WIDTH, 16384); write_csr(CSR_VP_HEIGHT, 16384);
                     write_csr(CSR_FACTOR, 1); end
            1: begin write_csr(CSR_VP_WIDTH, 0); write_csr(CSR_VP_HEIGHT, 0);
                     write_csr(CSR_FACTOR, 0); end
            2: begin write_csr(CSR_VP_WIDTH, 32'hFFFF_FFFF); write_csr(CSR_VP_HEIGHT, 1);
                     write_csr(CSR_FACTOR, 32'hFFFF_FFFF); end
            3: begin write_csr(CSR_VP_WIDTH, 1); write_csr(CSR_VP_HEIGHT, 16384);
                     write_csr(CSR_FACTOR, 256); end
            4: begin write_csr(CSR_VP_WIDTH, 640); write_csr(CSR_VP_HEIGHT, 480);
                     write_csr(CSR_FACTOR, 3); end
            default: begin write_csr(CSR_VP_WIDTH, $urandom_range(16384, 1));
                     write_csr(CSR_VP_HEIGHT, $urandom_range(16384, 1));
                     write_csr(CSR_FACTOR, $urandom_range(300)); end
         endcase
         if (phase < 2) begin send_idle_pct = 32; recv_idle_pct = 62; end
         else if (phase < 4) begin send_idle_pct = 62; recv_idle_pct = 32; end
         else begin send_idle_pct = 0; recv_idle_pct = 0; end
         if (phase == 4) hold_cycles = 1500;
         left = RANDOM_ITEMS / NUM_PHASES;
         while (left > 0) begin
            n = $urandom_range(12, 1);
            pairs = $urandom_range(1);
            for (int k = 0; k < n && left > 0; k++) begin
               v.x = rand_clip();
               v.y = rand_clip();
               v.w = rand_w();
               v.index = $urandom;
               v.typed = 0;
               v.coord = 0;
               if ($urandom_range(9) == 0) begin
                  v.start = $urandom_range(1);
                  v.kind = $urandom_range(1);
               end else begin
                  v.start = (k == 0);
                  v.kind = pairs ? LINE_PAIRS : LINE_STRIP;
               end
               send_vertex(v);
               left--;
            end
         end
      end
      req_valid <= 1'b0;
      while (pending_coords.size() != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);
      if (error_count == 0 && pending_coords.size() == 0)
         $display("line_stipple_distance_coords_unit test passed");
      else
         $display("line_stipple_distance_coords_unit test failed");
      $finish;
   end
endmodule
